FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSC_ASSERT_IMP(label, clk, rst, ante, cons)

`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// constants, types and elaboration-time table builders for the cordic core
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int ITERATIONS = 32;
  localparam int STEP_W     = $clog2(ITERATIONS + 1);
  localparam int IDX_W      = $clog2(ITERATIONS);
  localparam int CFG_W      = 6;
  localparam int OUT_W      = 32;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam logic signed [63:0] PI_Q58         = 64'sh0C90_FDAA_2216_8C23;
  localparam logic signed [63:0] HALF_PI_Q58    = 64'sh0648_7ED5_110B_4612;
  localparam logic signed [63:0] NEG_HALF_PI    = -HALF_PI_Q58;
  localparam logic signed [63:0] THREE_HALF_PI  = PI_Q58 + HALF_PI_Q58;
  localparam logic signed [63:0] TWO_PI_Q58     = PI_Q58 + PI_Q58;
  localparam logic signed [63:0] ONE_Q60        = 64'sh1000_0000_0000_0000;
  localparam logic [63:0]        PI4_Q62        = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0]        INV_SQRT2_Q62  = 64'h2D41_3CCC_FE77_9921;
  localparam logic [63:0]        ONE_Q62        = 64'h4000_0000_0000_0000;
  localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;

  // register map, index taken from paddr[2]
  localparam logic REG_ITER_LIMIT = 1'b0;
  localparam logic [CFG_W-1:0] ITER_LIMIT_RST = CFG_W'(32);

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic signed [63:0] atan_entry(input int i);
    logic [63:0] s;
    logic [63:0] term;
    int e;
    s = 64'd0;
    if (i == 0) begin
      s = PI4_Q62;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          if ((k % 2) == 1) s = s - term;
          else s = s + term;
        end
      end
    end
    return (s + 64'd8) >> 4;
  endfunction

  function automatic logic [63:0] gain_factor(input int i);
    logic [63:0] f;
    logic [63:0] t;
    f = ONE_Q62;
    t = ONE_Q62;
    if (i == 0) begin
      f = INV_SQRT2_Q62;
    end else begin
      for (int k = 1; k < 64; k++) begin
        if (t != 64'd0) begin
          t = t * 64'(2 * k - 1);
          t = t / 64'(2 * k);
          t = (2 * i >= 64) ? 64'd0 : (t >> (2 * i));
          if ((k % 2) == 1) f = f - t;
          else f = f + t;
        end
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] gain_entry(input int n);
    logic [63:0] g;
    g = ONE_Q62;
    for (int i = 0; i < ITERATIONS; i++) begin
      if (i < n) g = mul_q62(g, gain_factor(i));
    end
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csc_mul64.sv
// ----------------------------------------------------------------------------
// csc_mul64
// 64 x 64 unsigned multiply over four 32 x 32 partial products, gives
// floor(a * b / 2^62)
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csc_mul64 (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] a,
  input  wire  [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  typedef enum logic [1:0] {
    SH0  = 2'd0,
    SH32 = 2'd1,
    SH64 = 2'd2
  } pos_t;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [1:0]   k;
  logic         busy;
  logic [63:0]  pp;
  pos_t         pp_pos;
  logic         pp_valid;
  logic [127:0] acc;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  pos_t         op_pos;
  logic [127:0] acc_add;

  always_comb begin
    case (k)
      2'd0: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
        op_pos = SH0;
      end
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
        op_pos = SH32;
      end
      2'd2: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
        op_pos = SH32;
      end
      default: begin
        op_a = a_r[63:32];
        op_b = b_r[63:32];
        op_pos = SH64;
      end
    endcase
  end

  always_comb begin
    case (pp_pos)
      SH0:     acc_add = {64'd0, pp};
      SH32:    acc_add = {32'd0, pp, 32'd0};
      SH64:    acc_add = {pp, 64'd0};
      default: acc_add = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pp_valid <= 1'b0;
      done <= 1'b0;
      k <= 2'd0;
    end else begin
      pp_valid <= busy;
      done <= pp_valid && (pp_pos == SH64);
      if (start) begin
        busy <= 1'b1;
        k <= 2'd0;
      end else if (busy) begin
        k <= k + 2'd1;
        if (k == 2'd3) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= 128'd0;
    end else if (pp_valid) begin
      acc <= acc + acc_add;
    end
    if (busy) begin
      pp <= {32'd0, op_a} * {32'd0, op_b};
      pp_pos <= op_pos;
    end
  end

  assign prod = acc[125:62];

  `CSC_ASSERT_IMP(a_done_idle, clk, rst, done, !busy && !pp_valid)
  `CSC_ASSERT_NEXT(a_last_pp, clk, rst, busy && (k == 2'd3) && !start, pp_valid && (pp_pos == SH64))
  `CSC_ASSERT_IMP(a_no_restart, clk, rst, busy, !start)

endmodule

`default_nettype wire

FILE: hw/rtl/cordic_sin_cos.sv
// ----------------------------------------------------------------------------
// cordic_sin_cos
// rotation-mode cordic sine and cosine of a q4.28 angle, results in q2.30
//
//   channel   signals                          direction
//   input     in_valid, in_ready, angle_in     transfer in
//   output    out_valid, out_ready, cos_out,   transfer out
//             sin_out, steps_used
//   config    psel, penable, pwrite, paddr,    apb register access
//             pwdata, prdata, pready
//
// between input transfers one angle passes through reduction, steps_used
// micro-rotations and a stop, the two gain multiplies on the shared 32 x 32
// multiplier, and the finish
// in_ready is high only while idle; a finished result may wait in the
// output register while the next angle is taken
// synchronous reset sets iteration_limit to 32 and empties the block
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cordic_sin_cos (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [31:0] angle_in,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out,
  output logic [5:0]         steps_used
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_ROTATE = 5'b00100,
    S_SCALE  = 5'b01000,
    S_WRITE  = 5'b10000
  } state_t;

  state_t                           state;
  logic [csc_pkg::CFG_W-1:0]        iteration_limit;
  csc_pkg::step_t                   lim;
  csc_pkg::step_t                   lim_next;
  csc_pkg::step_t                   n;
  logic signed [63:0]               a;
  logic signed [63:0]               x;
  logic signed [63:0]               y;
  logic                             flip;
  logic                             comp;
  logic                             mul_start;
  logic                             mul_done;
  logic [63:0]                      mul_prod;
  logic signed [31:0]               cos_res;
  logic signed [31:0]               sin_res;
  logic signed [63:0]               atan_rom [0:csc_pkg::ITERATIONS-1];
  logic [63:0]                      gain_rom [0:csc_pkg::ITERATIONS];
  logic signed [63:0]               dx;
  logic signed [63:0]               dy;
  logic signed [63:0]               atan_n;
  logic signed [63:0]               c_sel;
  logic [63:0]                      c_mag;
  logic                             neg;
  logic [62:0]                      rnd;
  logic [32:0]                      r;
  logic [30:0]                      r_cap;
  logic [31:0]                      res_val;

  // constant tables, built at elaboration
  for (genvar j = 0; j < csc_pkg::ITERATIONS; j++) begin : g_atan
    localparam logic signed [63:0] ATAN_J = csc_pkg::atan_entry(j);
    assign atan_rom[j] = ATAN_J;
  end

  for (genvar j = 0; j <= csc_pkg::ITERATIONS; j++) begin : g_gain
    localparam logic [63:0] GAIN_J = csc_pkg::gain_entry(j);
    assign gain_rom[j] = GAIN_J;
  end

  // register port
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == csc_pkg::REG_ITER_LIMIT) begin
      prdata = {{(32 - csc_pkg::CFG_W){1'b0}}, iteration_limit};
    end else begin
      prdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= csc_pkg::ITER_LIMIT_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == csc_pkg::REG_ITER_LIMIT)) begin
      iteration_limit <= pwdata[csc_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (iteration_limit == '0) begin
      lim_next = csc_pkg::step_t'(1);
    end else if (int'(iteration_limit) > csc_pkg::ITERATIONS) begin
      lim_next = csc_pkg::step_t'(csc_pkg::ITERATIONS);
    end else begin
      lim_next = csc_pkg::step_t'(iteration_limit);
    end
  end

  // shared micro-rotation unit
  always_comb begin
    dx = y >>> n;
    dy = x >>> n;
    atan_n = atan_rom[n[csc_pkg::IDX_W-1:0]];
  end

  // rounding and saturation of the scaled magnitude
  always_comb begin
    c_sel = comp ? y : x;
    c_mag = c_sel[63] ? 64'(-c_sel) : 64'(c_sel);
    neg = c_sel[63] ^ flip;
    rnd = mul_prod[62:0] + {33'd0, 1'b1, 29'd0};
    r = rnd[62:30];
    r_cap = (r > {2'b00, csc_pkg::ONE_Q30}) ? csc_pkg::ONE_Q30 : r[30:0];
    res_val = neg ? (32'd0 - {1'b0, r_cap}) : {1'b0, r_cap};
  end

  csc_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (c_mag),
    .b     (gain_rom[n]),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      comp <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && out_ready && (state != S_WRITE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (!(a < csc_pkg::NEG_HALF_PI) && !(a >= csc_pkg::THREE_HALF_PI)) begin
            state <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          if ((a == 64'sd0) || (n == lim)) begin
            state <= S_SCALE;
            comp <= 1'b0;
            mul_start <= 1'b1;
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            if (!comp) begin
              comp <= 1'b1;
              mul_start <= 1'b1;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          a <= {{2{angle_in[31]}}, angle_in, 30'd0};
          x <= csc_pkg::ONE_Q60;
          y <= 64'sd0;
          n <= '0;
          flip <= 1'b0;
          lim <= lim_next;
        end
      end
      S_REDUCE: begin
        if (a < csc_pkg::NEG_HALF_PI) begin
          a <= a + csc_pkg::TWO_PI_Q58;
        end else if (a >= csc_pkg::THREE_HALF_PI) begin
          a <= a - csc_pkg::TWO_PI_Q58;
        end else if (a > csc_pkg::HALF_PI_Q58) begin
          a <= a - csc_pkg::PI_Q58;
          flip <= 1'b1;
        end
      end
      S_ROTATE: begin
        if ((a != 64'sd0) && (n != lim)) begin
          if (!a[63]) begin
            x <= x - dx;
            y <= y + dy;
            a <= a - atan_n;
          end else begin
            x <= x + dx;
            y <= y - dy;
            a <= a + atan_n;
          end
          n <= n + csc_pkg::step_t'(1);
        end
      end
      S_SCALE: begin
        if (mul_done) begin
          if (!comp) cos_res <= res_val;
          else sin_res <= res_val;
        end
      end
      S_WRITE: begin
        if (!out_valid || out_ready) begin
          cos_out <= cos_res;
          sin_out <= sin_res;
          steps_used <= 6'(n);
        end
      end
      default: begin
      end
    endcase
  end

  `CSC_ASSERT_IMP(a_step_bound, clk, rst, state == S_ROTATE, n <= lim)
  `CSC_ASSERT_IMP(a_lim_range, clk, rst, state != S_IDLE,
                  (lim != '0) && (int'(lim) <= csc_pkg::ITERATIONS))
  `CSC_ASSERT_IMP(a_reduced, clk, rst, (state == S_ROTATE) && (n == '0),
                  (a >= csc_pkg::NEG_HALF_PI) && (a <= csc_pkg::HALF_PI_Q58))
  `CSC_ASSERT_IMP(a_mul_owner, clk, rst, mul_done, state == S_SCALE)
  `CSC_ASSERT_NEXT(a_scale_start, clk, rst, (state == S_ROTATE) && $past(state == S_ROTATE) &&
                   ((a == 64'sd0) || (n == lim)), mul_start && !comp)

endmodule

`default_nettype wire
